// File: design/shli_pkg.sv
// shared types and constants for the symbol hash lookup and insert block
// used by shli_front, shli_back and symbol_hash_lookup_insert
`default_nettype none

package shli_pkg;

  localparam int HASH_W      = 16;
  localparam int CHAR_W      = 8;
  localparam int NAME_CHARS  = 8;
  localparam int NAME_W      = NAME_CHARS * CHAR_W;
  localparam int NAME_IDX_W  = $clog2(NAME_CHARS);
  localparam int CHAR_CNT_W  = 4;

  localparam int SLOT_W      = 10;
  localparam int TABLE_SLOTS = 1 << SLOT_W;
  localparam int STRIDE_W    = HASH_W - SLOT_W;
  localparam int POS_W       = SLOT_W + 2;

  localparam int MAX_ENTRIES = 1024;
  localparam int ENTRY_W     = $clog2(MAX_ENTRIES);
  localparam int ENTRY_CNT_W = 11;
  localparam int INDEX_W     = 10;

  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [NAME_W-1:0] name;
    logic              unhashed;
  } job_t;

  typedef struct packed {
    logic               valid;
    logic [ENTRY_W-1:0] entry;
  } slot_word_t;

endpackage

`default_nettype wire

// File: design/symbol_hash_lookup_insert.sv
// top level of the symbol hash lookup and insert block
// depends on shli_pkg, shli_front and shli_back
//
// channel  direction  handshake             payload
// in       input      in_valid_i/in_stall_o kind_i, char_code_i, unhashed_i
// out      output     out_valid_o/out_stall_i entry_index_o, user_symbol_o, created_o,
//                                           table_overflow_o, store_full_o
// cfg      input      cfg_we_i              cfg_data_i (user_base)
//
// a character transaction updates hash and name; end transactions queue two deep
// an end transaction leaves the queue from idle, then each probe runs step, slot read,
// name read and compare, stopping at the slot read when it finds an empty slot
// and at the step on overflow; an unhashed one needs no probe; then a result state
// after reset a pass over all 1024 slots clears slot memory; input stalls meanwhile
// as well as while the queue is full; the result waits in its register
`default_nettype none

module symbol_hash_lookup_insert (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [shli_pkg::ENTRY_CNT_W-1:0] cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire                              kind_i,
  input  wire  [shli_pkg::CHAR_W-1:0]      char_code_i,
  input  wire                              unhashed_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [shli_pkg::INDEX_W-1:0]     entry_index_o,
  output logic                             user_symbol_o,
  output logic                             created_o,
  output logic                             table_overflow_o,
  output logic                             store_full_o
);
  import shli_pkg::*;

  logic busy, q_valid, q_pop;
  job_t q_data;

  shli_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .char_code_i (char_code_i),
    .unhashed_i  (unhashed_i),
    .busy_i      (busy),
    .q_valid_o   (q_valid),
    .q_data_o    (q_data),
    .q_pop_i     (q_pop)
  );

  shli_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .busy_o           (busy),
    .q_valid_i        (q_valid),
    .q_data_i         (q_data),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .entry_index_o    (entry_index_o),
    .user_symbol_o    (user_symbol_o),
    .created_o        (created_o),
    .table_overflow_o (table_overflow_o),
    .store_full_o     (store_full_o)
  );

  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({created_o, table_overflow_o, store_full_o}))
    else $error("more than one outcome flag set");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (table_overflow_o || store_full_o)) |->
      (entry_index_o == '0 && !user_symbol_o))
    else $error("failed lookup carries an entry");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (!out_valid_o && !q_pop && in_stall_o))
    else $error("activity during slot clearing");

endmodule

`default_nettype wire

// File: design/shli_front.sv
// front part: hashes characters, collects the name and queues finished symbols
// depends on shli_pkg
`default_nettype none

module shli_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire                          kind_i,
  input  wire  [shli_pkg::CHAR_W-1:0]  char_code_i,
  input  wire                          unhashed_i,
  input  wire                          busy_i,
  output logic                         q_valid_o,
  output shli_pkg::job_t               q_data_o,
  input  wire                          q_pop_i
);
  import shli_pkg::*;

  logic [HASH_W-1:0]     hash_q, hash_d;
  logic [NAME_W-1:0]     name_q, name_d;
  logic [CHAR_CNT_W-1:0] cnt_q, cnt_d;
  logic [HASH_W-1:0]     hsum;
  job_t                  ent_q [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]     qcnt_q;
  logic                  accept, push;

  assign in_stall_o = busy_i || (qcnt_q == QCNT_W'(QDEPTH));
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = accept && (kind_i == KIND_END);
  assign q_valid_o  = (qcnt_q != '0);
  assign q_data_o   = ent_q[rd_ptr_q];
  assign hsum       = hash_q + HASH_W'(char_code_i);

  always_comb begin
    hash_d = hash_q;
    name_d = name_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (kind_i == KIND_CHAR) begin
        hash_d = {hsum[CHAR_W-1:0], hsum[HASH_W-1:CHAR_W]};
        if (cnt_q < CHAR_CNT_W'(NAME_CHARS)) begin
          name_d[CHAR_W*cnt_q[NAME_IDX_W-1:0] +: CHAR_W] = char_code_i;
          cnt_d = cnt_q + 1'b1;
        end
      end else begin
        hash_d = '0;
        name_d = '0;
        cnt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q   <= '0;
      name_q   <= '0;
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      qcnt_q   <= '0;
    end else begin
      hash_q <= hash_d;
      name_q <= name_d;
      cnt_q  <= cnt_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (q_pop_i && q_valid_o) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !(q_pop_i && q_valid_o)) begin
        qcnt_q <= qcnt_q + 1'b1;
      end else if (!push && q_pop_i && q_valid_o) begin
        qcnt_q <= qcnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= '{hash: hash_q, name: name_q, unhashed: unhashed_i};
    end
  end

endmodule

`default_nettype wire

// File: design/shli_back.sv
// back part: probe engine over the slot and name memories, allocation, result register
// depends on shli_pkg
`default_nettype none

module shli_back (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [shli_pkg::ENTRY_CNT_W-1:0] cfg_data_i,
  output logic                             busy_o,
  input  wire                              q_valid_i,
  input  shli_pkg::job_t                   q_data_i,
  output logic                             q_pop_o,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [shli_pkg::INDEX_W-1:0]     entry_index_o,
  output logic                             user_symbol_o,
  output logic                             created_o,
  output logic                             table_overflow_o,
  output logic                             store_full_o
);
  import shli_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_STEP  = 3'd2;
  localparam logic [2:0] ST_SLOT  = 3'd3;
  localparam logic [2:0] ST_NAME  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  slot_word_t             slot_mem [TABLE_SLOTS];
  logic [NAME_W-1:0]      name_mem [MAX_ENTRIES];

  logic [2:0]             state_q, state_d;
  logic [SLOT_W-1:0]      clr_q, clr_d;
  job_t                   job_q, job_d;
  logic [SLOT_W-1:0]      pos_q, pos_d;
  logic                   around_q, around_d;
  logic [ENTRY_CNT_W-1:0] next_q, next_d;
  logic [ENTRY_CNT_W-1:0] ubase_q;
  logic                   res_have_q, res_have_d;
  logic [ENTRY_CNT_W-1:0] res_entry_q, res_entry_d;
  logic                   res_created_q, res_created_d;
  logic                   res_ovf_q, res_ovf_d;
  logic                   res_full_q, res_full_d;

  slot_word_t             slot_rd_q;
  logic [NAME_W-1:0]      name_rd_q;
  logic                   slot_we, slot_re, name_we, name_re;
  logic [SLOT_W-1:0]      slot_waddr, slot_raddr;
  slot_word_t             slot_wdata;
  logic [ENTRY_W-1:0]     name_waddr, name_raddr;
  logic [NAME_W-1:0]      name_wdata;

  logic                   store_full;
  logic [POS_W-1:0]       diff, wrapped, dec;
  logic                   wrap;
  logic [ENTRY_CNT_W-1:0] rel;

  assign store_full = (next_q >= ENTRY_CNT_W'(MAX_ENTRIES));
  assign diff       = POS_W'(pos_q) - POS_W'(job_q.hash[HASH_W-1:SLOT_W]);
  assign wrap       = diff[POS_W-1] || (diff == '0);
  assign wrapped    = wrap ? diff + POS_W'(TABLE_SLOTS) : diff;
  assign dec        = wrapped - 1'b1;

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    job_d         = job_q;
    pos_d         = pos_q;
    around_d      = around_q;
    next_d        = next_q;
    res_have_d    = res_have_q;
    res_entry_d   = res_entry_q;
    res_created_d = res_created_q;
    res_ovf_d     = res_ovf_q;
    res_full_d    = res_full_q;
    q_pop_o       = 1'b0;
    slot_we       = 1'b0;
    slot_waddr    = pos_q;
    slot_wdata    = '{valid: 1'b1, entry: next_q[ENTRY_W-1:0]};
    slot_re       = 1'b0;
    slot_raddr    = dec[SLOT_W-1:0];
    name_we       = 1'b0;
    name_waddr    = next_q[ENTRY_W-1:0];
    name_wdata    = job_q.name;
    name_re       = 1'b0;
    name_raddr    = slot_rd_q.entry;

    case (state_q)
      ST_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_q;
        slot_wdata = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o       = 1'b1;
          job_d         = q_data_i;
          pos_d         = q_data_i.hash[SLOT_W-1:0];
          around_d      = 1'b0;
          res_have_d    = 1'b0;
          res_entry_d   = '0;
          res_created_d = 1'b0;
          res_ovf_d     = 1'b0;
          res_full_d    = 1'b0;
          if (q_data_i.unhashed) begin
            state_d = ST_DONE;
            if (store_full) begin
              res_full_d = 1'b1;
            end else begin
              name_we       = 1'b1;
              name_wdata    = q_data_i.name;
              res_have_d    = 1'b1;
              res_created_d = 1'b1;
              res_entry_d   = next_q;
              next_d        = next_q + 1'b1;
            end
          end else begin
            state_d = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        if (wrap && around_q) begin
          res_ovf_d = 1'b1;
          state_d   = ST_DONE;
        end else begin
          around_d = around_q || wrap;
          pos_d    = dec[SLOT_W-1:0];
          slot_re  = 1'b1;
          state_d  = ST_SLOT;
        end
      end
      ST_SLOT: begin
        if (slot_rd_q.valid) begin
          name_re = 1'b1;
          state_d = ST_NAME;
        end else begin
          state_d = ST_DONE;
          if (store_full) begin
            res_full_d = 1'b1;
          end else begin
            slot_we       = 1'b1;
            name_we       = 1'b1;
            res_have_d    = 1'b1;
            res_created_d = 1'b1;
            res_entry_d   = next_q;
            next_d        = next_q + 1'b1;
          end
        end
      end
      ST_NAME: begin
        if (name_rd_q == job_q.name) begin
          res_have_d  = 1'b1;
          res_entry_d = ENTRY_CNT_W'(slot_rd_q.entry);
          state_d     = ST_DONE;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_DONE: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      next_q   <= '0;
      ubase_q  <= '0;
      around_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      next_q   <= next_d;
      around_q <= around_d;
      if (cfg_we_i) begin
        ubase_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q         <= job_d;
    pos_q         <= pos_d;
    res_have_q    <= res_have_d;
    res_entry_q   <= res_entry_d;
    res_created_q <= res_created_d;
    res_ovf_q     <= res_ovf_d;
    res_full_q    <= res_full_d;
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_raddr];
    end
  end

  // name memory
  always_ff @(posedge clk_i) begin
    if (name_we) begin
      name_mem[name_waddr] <= name_wdata;
    end
    if (name_re) begin
      name_rd_q <= name_mem[name_raddr];
    end
  end

  assign rel              = res_entry_q - ubase_q;
  assign busy_o           = (state_q == ST_CLEAR);
  assign out_valid_o      = (state_q == ST_DONE);
  assign user_symbol_o    = res_have_q && (res_entry_q >= ubase_q);
  assign entry_index_o    = !res_have_q    ? '0 :
                            user_symbol_o  ? rel[INDEX_W-1:0] :
                                             res_entry_q[INDEX_W-1:0];
  assign created_o        = res_created_q;
  assign table_overflow_o = res_ovf_q;
  assign store_full_o     = res_full_q;

endmodule

`default_nettype wire
